[rtl/core/vfc_pkg.sv]
package vfc_pkg;

  localparam int GRID_WIDTH  = 8;
  localparam int GRID_HEIGHT = 8;
  localparam int GRID_DEPTH  = 32;

  localparam int OP_W      = 2;
  localparam int COL_W     = 3;
  localparam int ROWF_W    = 3;
  localparam int SLICE_W   = 5;
  localparam int COLOR_W   = 2;
  localparam int PLANE_W   = 8;
  localparam int MASK_W    = 6;
  localparam int COUNT_W   = 3;
  localparam int TOTAL_W   = 14;

  localparam int SCAN_LEN   = 8;
  localparam int LOAD_LANES = 8;
  localparam int ROWS       = GRID_HEIGHT * GRID_DEPTH;
  localparam int ROW_AW     = $clog2(ROWS);
  localparam int LANE_W     = $clog2(GRID_WIDTH);
  localparam int ROW_W      = GRID_WIDTH * COLOR_W;
  localparam int NB_COUNT   = 5;
  localparam int STEP_W     = $clog2(NB_COUNT + 1);

  localparam logic [TOTAL_W:0] TOTAL_MAX = (TOTAL_W + 1)'((1 << TOTAL_W) - 1);

  typedef logic [GRID_WIDTH-1:0][COLOR_W-1:0] vrow_t;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_SCAN  = 2'd3
  } op_e;

  // Row fetched for a scan: the row itself and its four neighbors in y and z.
  typedef enum logic [STEP_W-1:0] {
    NB_CENTER = 3'd0,
    NB_UP     = 3'd1,
    NB_DOWN   = 3'd2,
    NB_FRONT  = 3'd3,
    NB_BACK   = 3'd4
  } nb_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_UPD_RD,
    ST_UPD_WB,
    ST_SCAN_RD,
    ST_SCAN_EMIT
  } state_e;

  typedef struct packed {
    logic             latch;
    logic             clear;
    logic             mem_rd;
    nb_e              rd_sel;
    logic             cap;
    nb_e              cap_sel;
    logic             mem_wr;
    logic             load_out;
    logic [COL_W-1:0] col;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic upd_ok;
    logic out_free;
  } status_t;

  function automatic logic [ROW_AW-1:0] row_addr(input int y, input int z);
    return ROW_AW'(y + z * GRID_HEIGHT);
  endfunction

endpackage

[rtl/core/vfc_in_if.sv]
interface vfc_in_if;
  logic                          valid;
  logic                          ready;
  logic [vfc_pkg::OP_W-1:0]      operation;
  logic [vfc_pkg::COL_W-1:0]     column;
  logic [vfc_pkg::ROWF_W-1:0]    row;
  logic [vfc_pkg::SLICE_W-1:0]   slice;
  logic [vfc_pkg::COLOR_W-1:0]   color;
  logic [vfc_pkg::PLANE_W-1:0]   plane_low;
  logic [vfc_pkg::PLANE_W-1:0]   plane_high;

  modport source (
    output valid, operation, column, row, slice, color, plane_low, plane_high,
    input  ready
  );
  modport sink (
    input  valid, operation, column, row, slice, color, plane_low, plane_high,
    output ready
  );
endinterface

[rtl/core/vfc_out_if.sv]
interface vfc_out_if;
  logic                          valid;
  logic                          ready;
  logic [vfc_pkg::COL_W-1:0]     out_column;
  logic [vfc_pkg::COLOR_W-1:0]   voxel_color;
  logic [vfc_pkg::MASK_W-1:0]    face_mask;
  logic [vfc_pkg::COUNT_W-1:0]   face_count;
  logic [vfc_pkg::TOTAL_W-1:0]   total_faces;
  logic                          last;

  modport source (
    output valid, out_column, voxel_color, face_mask, face_count, total_faces, last,
    input  ready
  );
  modport sink (
    input  valid, out_column, voxel_color, face_mask, face_count, total_faces, last,
    output ready
  );
endinterface

[rtl/core/voxel_exposed_face_cull_core.sv]
// Channel  Dir  Payload                                                    Accepted when
// in_i     in   operation column row slice color plane_low plane_high      valid && ready
// res_o    out  out_column voxel_color face_mask face_count total_faces    valid && ready
//              last
//
// Voxel write and tile-row load each go row read, merge, write-back.
// A row scan first fetches the row and its four y/z neighbors through the
// single read port of the row memory, then delivers one result per cycle unless stalled.
// Reset clears a valid bit per row, so the grid reads empty at once; no clearing pass.
// A stalled result holds the scan in place; a new request is taken once the last result
// of the previous one sits in the output register.
module voxel_exposed_face_cull_core (
  input logic clk_i,
  input logic rst_ni,
  vfc_in_if.sink   in_i,
  vfc_out_if.source res_o
);

  vfc_pkg::cmd_t    cmd;
  vfc_pkg::status_t status;
  logic             in_ready;

  vfc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (vfc_pkg::op_e'(in_i.operation)),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vfc_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .item_op_i    (in_i.operation),
    .item_x_i     (in_i.column),
    .item_y_i     (in_i.row),
    .item_z_i     (in_i.slice),
    .item_color_i (in_i.color),
    .item_lo_i    (in_i.plane_low),
    .item_hi_i    (in_i.plane_high),
    .res_ready_i  (res_o.ready),
    .res_valid_o  (res_o.valid),
    .res_column_o (res_o.out_column),
    .res_color_o  (res_o.voxel_color),
    .res_mask_o   (res_o.face_mask),
    .res_count_o  (res_o.face_count),
    .res_total_o  (res_o.total_faces),
    .res_last_o   (res_o.last)
  );

  assign in_i.ready = in_ready;

endmodule

[rtl/core/vfc_ram.sv]
module vfc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/vfc_ctrl.sv]
module vfc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  vfc_pkg::op_e     in_op_i,
  output logic             in_ready_o,
  input  vfc_pkg::status_t status_i,
  output vfc_pkg::cmd_t    cmd_o
);

  vfc_pkg::state_e                 state_q, state_d;
  logic [vfc_pkg::STEP_W-1:0]      step_q, step_d;
  logic [vfc_pkg::COL_W-1:0]       col_q, col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vfc_pkg::ST_IDLE;
      step_q  <= '0;
      col_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      col_q   <= col_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    col_d          = col_q;
    in_ready_o     = 1'b0;
    cmd_o.latch    = 1'b0;
    cmd_o.clear    = 1'b0;
    cmd_o.mem_rd   = 1'b0;
    cmd_o.rd_sel   = vfc_pkg::NB_CENTER;
    cmd_o.cap      = 1'b0;
    cmd_o.cap_sel  = vfc_pkg::NB_CENTER;
    cmd_o.mem_wr   = 1'b0;
    cmd_o.load_out = 1'b0;
    cmd_o.col      = col_q;
    cmd_o.last     = (col_q == vfc_pkg::COL_W'(vfc_pkg::SCAN_LEN - 1));

    unique case (state_q)
      vfc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        step_d     = '0;
        col_d      = '0;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          unique case (in_op_i)
            vfc_pkg::OP_CLEAR: state_d = vfc_pkg::ST_CLEAR;
            vfc_pkg::OP_WRITE,
            vfc_pkg::OP_LOAD:  state_d = vfc_pkg::ST_UPD_RD;
            vfc_pkg::OP_SCAN:  state_d = vfc_pkg::ST_SCAN_RD;
            default:           state_d = vfc_pkg::ST_IDLE;
          endcase
        end
      end

      vfc_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = vfc_pkg::ST_IDLE;
      end

      // Write and load both rewrite one row: read it, merge, write it back.
      vfc_pkg::ST_UPD_RD: begin
        if (status_i.upd_ok) begin
          cmd_o.mem_rd = 1'b1;
          state_d      = vfc_pkg::ST_UPD_WB;
        end else begin
          state_d = vfc_pkg::ST_IDLE;
        end
      end

      vfc_pkg::ST_UPD_WB: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = vfc_pkg::ST_IDLE;
      end

      // Read issued at step s lands in the RAM output register and is captured at step s+1.
      vfc_pkg::ST_SCAN_RD: begin
        if (step_q < vfc_pkg::STEP_W'(vfc_pkg::NB_COUNT)) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = vfc_pkg::nb_e'(step_q);
        end
        if (step_q != '0) begin
          cmd_o.cap     = 1'b1;
          cmd_o.cap_sel = vfc_pkg::nb_e'(step_q - vfc_pkg::STEP_W'(1));
        end
        if (step_q == vfc_pkg::STEP_W'(vfc_pkg::NB_COUNT)) begin
          state_d = vfc_pkg::ST_SCAN_EMIT;
        end else begin
          step_d = step_q + vfc_pkg::STEP_W'(1);
        end
      end

      vfc_pkg::ST_SCAN_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (cmd_o.last) begin
            state_d = vfc_pkg::ST_IDLE;
          end else begin
            col_d = col_q + vfc_pkg::COL_W'(1);
          end
        end
      end

      default: state_d = vfc_pkg::ST_IDLE;
    endcase
  end

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> status_i.out_free)
    else $error("result loaded into a full output register");

  a_wb_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mem_wr |-> $past(cmd_o.mem_rd))
    else $error("row write-back without a preceding row read");

  a_rd_wr_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.mem_rd && cmd_o.mem_wr))
    else $error("row memory read and written in the same cycle");

endmodule

[rtl/core/vfc_datapath.sv]
module vfc_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  vfc_pkg::cmd_t                 cmd_i,
  output vfc_pkg::status_t              status_o,
  input  logic [vfc_pkg::OP_W-1:0]      item_op_i,
  input  logic [vfc_pkg::COL_W-1:0]     item_x_i,
  input  logic [vfc_pkg::ROWF_W-1:0]    item_y_i,
  input  logic [vfc_pkg::SLICE_W-1:0]   item_z_i,
  input  logic [vfc_pkg::COLOR_W-1:0]   item_color_i,
  input  logic [vfc_pkg::PLANE_W-1:0]   item_lo_i,
  input  logic [vfc_pkg::PLANE_W-1:0]   item_hi_i,
  input  logic                          res_ready_i,
  output logic                          res_valid_o,
  output logic [vfc_pkg::COL_W-1:0]     res_column_o,
  output logic [vfc_pkg::COLOR_W-1:0]   res_color_o,
  output logic [vfc_pkg::MASK_W-1:0]    res_mask_o,
  output logic [vfc_pkg::COUNT_W-1:0]   res_count_o,
  output logic [vfc_pkg::TOTAL_W-1:0]   res_total_o,
  output logic                          res_last_o
);

  // Latched item
  vfc_pkg::op_e                  op_q;
  logic [vfc_pkg::COL_W-1:0]     x_q;
  logic [vfc_pkg::ROWF_W-1:0]    y_q;
  logic [vfc_pkg::SLICE_W-1:0]   z_q;
  logic [vfc_pkg::COLOR_W-1:0]   color_q;
  logic [vfc_pkg::PLANE_W-1:0]   lo_q;
  logic [vfc_pkg::PLANE_W-1:0]   hi_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= vfc_pkg::op_e'(item_op_i);
      x_q     <= item_x_i;
      y_q     <= item_y_i;
      z_q     <= item_z_i;
      color_q <= item_color_i;
      lo_q    <= item_lo_i;
      hi_q    <= item_hi_i;
    end
  end

  logic x_ok, y_ok, z_ok;
  assign x_ok = int'(x_q) < vfc_pkg::GRID_WIDTH;
  assign y_ok = int'(y_q) < vfc_pkg::GRID_HEIGHT;
  assign z_ok = int'(z_q) < vfc_pkg::GRID_DEPTH;

  assign status_o.upd_ok = y_ok && z_ok && ((op_q == vfc_pkg::OP_LOAD) || x_ok);

  // Row address for the selected neighbor; rows off the grid read as empty.
  logic [vfc_pkg::ROW_AW-1:0] rd_addr;
  logic                       rd_addr_ok;
  logic [vfc_pkg::ROW_AW-1:0] ctr_addr;

  assign ctr_addr = vfc_pkg::row_addr(int'(y_q), int'(z_q));

  always_comb begin
    case (cmd_i.rd_sel)
      vfc_pkg::NB_CENTER: begin
        rd_addr    = ctr_addr;
        rd_addr_ok = y_ok && z_ok;
      end
      vfc_pkg::NB_UP: begin
        rd_addr    = vfc_pkg::row_addr(int'(y_q) - 1, int'(z_q));
        rd_addr_ok = y_ok && z_ok && (y_q != '0);
      end
      vfc_pkg::NB_DOWN: begin
        rd_addr    = vfc_pkg::row_addr(int'(y_q) + 1, int'(z_q));
        rd_addr_ok = z_ok && (int'(y_q) + 1 < vfc_pkg::GRID_HEIGHT);
      end
      vfc_pkg::NB_FRONT: begin
        rd_addr    = vfc_pkg::row_addr(int'(y_q), int'(z_q) - 1);
        rd_addr_ok = y_ok && z_ok && (z_q != '0);
      end
      vfc_pkg::NB_BACK: begin
        rd_addr    = vfc_pkg::row_addr(int'(y_q), int'(z_q) + 1);
        rd_addr_ok = y_ok && (int'(z_q) + 1 < vfc_pkg::GRID_DEPTH);
      end
      default: begin
        rd_addr    = '0;
        rd_addr_ok = 1'b0;
      end
    endcase
  end

  // One valid bit per row: a row never written since the last clear reads as empty.
  logic [vfc_pkg::ROWS-1:0] row_valid_q;
  logic                     rd_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_ok_q     <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        row_valid_q <= '0;
      end else if (cmd_i.mem_wr) begin
        row_valid_q[ctr_addr] <= 1'b1;
      end
      if (cmd_i.mem_rd) begin
        rd_ok_q <= rd_addr_ok && row_valid_q[rd_addr];
      end
    end
  end

  logic [vfc_pkg::ROW_W-1:0] ram_rd_data;
  vfc_pkg::vrow_t            rd_row;
  vfc_pkg::vrow_t            wr_row;

  vfc_ram #(
    .WIDTH (vfc_pkg::ROW_W),
    .DEPTH (vfc_pkg::ROWS)
  ) u_row_ram (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.mem_wr),
    .wr_addr_i (ctr_addr),
    .wr_data_i (wr_row),
    .rd_en_i   (cmd_i.mem_rd),
    .rd_addr_i (rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign rd_row = rd_ok_q ? vfc_pkg::vrow_t'(ram_rd_data) : '0;

  // Merge for write-back: a single voxel, or the planar decode of a tile row.
  always_comb begin
    for (int i = 0; i < vfc_pkg::GRID_WIDTH; i++) begin
      wr_row[i] = rd_row[i];
      if (op_q == vfc_pkg::OP_WRITE && int'(x_q) == i) begin
        wr_row[i] = color_q;
      end else if (op_q == vfc_pkg::OP_LOAD && i < vfc_pkg::LOAD_LANES) begin
        wr_row[i] = {hi_q[vfc_pkg::PLANE_W-1-i], lo_q[vfc_pkg::PLANE_W-1-i]};
      end
    end
  end

  vfc_pkg::vrow_t center_q, up_q, down_q, front_q, back_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      case (cmd_i.cap_sel)
        vfc_pkg::NB_CENTER: center_q <= rd_row;
        vfc_pkg::NB_UP:     up_q     <= rd_row;
        vfc_pkg::NB_DOWN:   down_q   <= rd_row;
        vfc_pkg::NB_FRONT:  front_q  <= rd_row;
        vfc_pkg::NB_BACK:   back_q   <= rd_row;
        default:            center_q <= center_q;
      endcase
    end
  end

  // Face evaluation for the column being emitted.
  logic [vfc_pkg::LANE_W-1:0]  lane;
  logic                        lane_ok;
  logic [vfc_pkg::COLOR_W-1:0] cur_color;
  logic [vfc_pkg::COLOR_W-1:0] left_color;
  logic [vfc_pkg::COLOR_W-1:0] right_color;
  logic [vfc_pkg::MASK_W-1:0]  mask;
  logic [vfc_pkg::COUNT_W-1:0] count;
  logic [vfc_pkg::TOTAL_W:0]   sum;
  logic [vfc_pkg::TOTAL_W-1:0] total_next;
  logic [vfc_pkg::TOTAL_W-1:0] total_q;

  assign lane    = vfc_pkg::LANE_W'(cmd_i.col);
  assign lane_ok = int'(cmd_i.col) < vfc_pkg::GRID_WIDTH;

  always_comb begin
    cur_color   = lane_ok ? center_q[lane] : '0;
    left_color  = (cmd_i.col == '0) ? '0
                : center_q[vfc_pkg::LANE_W'(int'(cmd_i.col) - 1)];
    right_color = (int'(cmd_i.col) + 1 >= vfc_pkg::GRID_WIDTH) ? '0
                : center_q[vfc_pkg::LANE_W'(int'(cmd_i.col) + 1)];
    if (cur_color != '0) begin
      mask = {back_q[lane] == '0, front_q[lane] == '0, down_q[lane] == '0,
              up_q[lane] == '0, right_color == '0, left_color == '0};
    end else begin
      mask = '0;
    end
    count      = vfc_pkg::COUNT_W'($countones(mask));
    sum        = {1'b0, total_q} + (vfc_pkg::TOTAL_W + 1)'(count);
    total_next = (sum > vfc_pkg::TOTAL_MAX) ? vfc_pkg::TOTAL_MAX[vfc_pkg::TOTAL_W-1:0]
               : sum[vfc_pkg::TOTAL_W-1:0];
  end

  logic                        res_valid_q;
  logic [vfc_pkg::COL_W-1:0]   res_column_q;
  logic [vfc_pkg::COLOR_W-1:0] res_color_q;
  logic [vfc_pkg::MASK_W-1:0]  res_mask_q;
  logic [vfc_pkg::COUNT_W-1:0] res_count_q;
  logic [vfc_pkg::TOTAL_W-1:0] res_total_q;
  logic                        res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      if (cmd_i.clear) begin
        total_q <= '0;
      end else if (cmd_i.load_out) begin
        total_q <= total_next;
      end
      if (cmd_i.load_out) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_column_q <= cmd_i.col;
      res_color_q  <= cur_color;
      res_mask_q   <= mask;
      res_count_q  <= count;
      res_total_q  <= total_next;
      res_last_q   <= cmd_i.last;
    end
  end

  assign status_o.out_free = !res_valid_q || res_ready_i;

  assign res_valid_o  = res_valid_q;
  assign res_column_o = res_column_q;
  assign res_color_o  = res_color_q;
  assign res_mask_o   = res_mask_q;
  assign res_count_o  = res_count_q;
  assign res_total_o  = res_total_q;
  assign res_last_o   = res_last_q;

  a_clear_zeroes_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (total_q == '0))
    else $error("face total not zero after clear");

  a_count_matches_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> (int'(res_count_q) == $countones(res_mask_q)))
    else $error("face count disagrees with face mask");

  a_empty_no_faces: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_color_q == '0) |-> (res_mask_q == '0))
    else $error("empty voxel reported with exposed faces");

  a_last_on_final_column: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_last_q)
      |-> (res_column_q == vfc_pkg::COL_W'(vfc_pkg::SCAN_LEN - 1)))
    else $error("last flag on a column other than the final one");

endmodule
